// ===== rtl/tcu_pkg.sv =====
// ----------------------------------------------------------------------------
// tcu_pkg
// shared types, constants and helpers of the 2d transform compose unit
// ----------------------------------------------------------------------------
package tcu_pkg;

   // node table depth, a power of two no smaller than the index fields
   localparam int NODES = 64;
   localparam int IDX_W = $clog2(NODES);

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [32:0] TRIG_ONE  = 33'sd1073741824;

   // request types
   localparam logic [1:0] RT_BOTH = 2'd0;
   localparam logic [1:0] RT_POS  = 2'd1;
   localparam logic [1:0] RT_MAT  = 2'd2;

   // what the shared multiplier does with a product
   typedef enum logic [1:0] {
      MK_LOCAL,
      MK_FIRST,
      MK_PAIR,
      MK_POS
   } mac_kind_type;

   typedef struct packed {
      logic signed [31:0] c0x;
      logic signed [31:0] c0y;
      logic signed [31:0] c1x;
      logic signed [31:0] c1y;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } node_type;

   // arctangent steps, 2^20 units per turn
   function automatic logic [19:0] atan_units(input logic [STEP_W-1:0] i);
      logic [19:0] v;
      begin
         case (i)
            4'd0:    v = 20'd131072;
            4'd1:    v = 20'd77376;
            4'd2:    v = 20'd40884;
            4'd3:    v = 20'd20753;
            4'd4:    v = 20'd10417;
            4'd5:    v = 20'd5213;
            4'd6:    v = 20'd2607;
            4'd7:    v = 20'd1304;
            4'd8:    v = 20'd652;
            4'd9:    v = 20'd326;
            4'd10:   v = 20'd163;
            4'd11:   v = 20'd81;
            4'd12:   v = 20'd41;
            4'd13:   v = 20'd20;
            4'd14:   v = 20'd10;
            default: v = 20'd5;
         endcase
         return v;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      begin
         if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
         else if (v < -66'sd2147483648)
            r = 32'sh80000000;
         else
            r = v[31:0];
         return r;
      end
   endfunction

endpackage

// ===== rtl/tcu_store.sv =====
// ----------------------------------------------------------------------------
// tcu_store
// node table, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tcu_store import tcu_pkg::*; (
   input  logic             clock,
   input  logic             we,
   input  logic [IDX_W-1:0] waddr,
   input  node_type         wdata,
   input  logic             re,
   input  logic [IDX_W-1:0] raddr_a,
   input  logic [IDX_W-1:0] raddr_b,
   output node_type         rdata_a,
   output node_type         rdata_b
);

   node_type mem [NODES];
   node_type rdata_a_ff;
   node_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== rtl/tcu_cordic.sv =====
// ----------------------------------------------------------------------------
// tcu_cordic
// iterative sine/cosine, one rotation step per cycle, q1.30 results
// ----------------------------------------------------------------------------
module tcu_cordic import tcu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        angle,
   output logic               done,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);

   logic                busy_ff, fin_ff, done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic signed [32:0]  x_ff, y_ff;
   logic signed [20:0]  z_ff;
   logic [1:0]          quad_ff;
   logic signed [31:0]  cos_ff, sin_ff;

   logic signed [32:0]  dx, dy, xc, yc;
   logic signed [20:0]  at;
   logic signed [31:0]  cx, cy;

   always_comb begin
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      at = $signed({1'b0, atan_units(step_ff)});
      // clamp to +-1.0
      if (x_ff > TRIG_ONE)       xc = TRIG_ONE;
      else if (x_ff < -TRIG_ONE) xc = -TRIG_ONE;
      else                       xc = x_ff;
      if (y_ff > TRIG_ONE)       yc = TRIG_ONE;
      else if (y_ff < -TRIG_ONE) yc = -TRIG_ONE;
      else                       yc = y_ff;
      cx = xc[31:0];
      cy = yc[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start | (busy_ff & (step_ff != STEP_W'(CORDIC_STEPS - 1)));
         fin_ff  <= busy_ff & (step_ff == STEP_W'(CORDIC_STEPS - 1));
         done_ff <= fin_ff;
      end
      if (start) begin
         step_ff <= '0;
         x_ff    <= CORDIC_X0;
         y_ff    <= '0;
         z_ff    <= $signed({3'b000, angle[13:0], 4'b0000});
         quad_ff <= angle[15:14];
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (!z_ff[20]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
      end
      if (fin_ff) begin
         // quadrant fold is exact
         case (quad_ff)
            2'd0: begin cos_ff <= cx;  sin_ff <= cy;  end
            2'd1: begin cos_ff <= -cy; sin_ff <= cx;  end
            2'd2: begin cos_ff <= -cx; sin_ff <= -cy; end
            default: begin cos_ff <= cy; sin_ff <= -cx; end
         endcase
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ===== rtl/tcu_mac.sv =====
// ----------------------------------------------------------------------------
// tcu_mac
// shared 32x32 multiplier with pair accumulate, rounding and saturation
// ----------------------------------------------------------------------------
module tcu_mac import tcu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               issue,
   input  mac_kind_type       kind,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   input  logic signed [31:0] addend,
   output logic signed [31:0] res
);

   logic signed [63:0] prod_ff, acc_ff;
   logic signed [31:0] add_ff;
   mac_kind_type       kind_ff;
   logic               vld_ff;

   logic signed [65:0] sum, rnd, pos;
   logic signed [63:0] lv;

   always_comb begin
      sum = 66'(acc_ff) + 66'(prod_ff);
      rnd = (sum + 66'sd32768) >>> 16;
      pos = rnd + 66'(add_ff);
      lv  = (prod_ff + 64'sd2097152) >>> 22;
      case (kind_ff)
         MK_LOCAL: res = lv[31:0];
         MK_PAIR:  res = sat32(rnd);
         MK_POS:   res = sat32(pos);
         default:  res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= issue;
      end
      if (issue) begin
         prod_ff <= a * b;
         kind_ff <= kind;
         add_ff  <= addend;
      end
      if (vld_ff && kind_ff == MK_FIRST) begin
         acc_ff <= prod_ff;
      end
   end

endmodule

// ===== rtl/hierarchical_2d_transform_compose_unit.sv =====
// ----------------------------------------------------------------------------
// hierarchical_2d_transform_compose_unit
// updates one scene node per transaction: local scale-rotate matrix and
// position, composed with the stored parent transform
// ----------------------------------------------------------------------------
//  channel  ports   direction  carries
//  request  req_*   in         node update transaction
//  response rsp_*   out        node's stored transform after the update
//
//  steps per transaction, accept to response valid:
//    table read, cordic, 16 products in turn in the shared multiplier,
//    table write, then the response
//  the next request is taken once the response has been taken
//  reset: synchronous, clears the sequencer and the cordic and multiplier control; the table is not cleared
//  a stalled response holds its payload and blocks new requests
// ----------------------------------------------------------------------------
module hierarchical_2d_transform_compose_unit import tcu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [5:0]         req_node_index,
   input  logic [5:0]         req_parent_index,
   input  logic               req_has_parent,
   input  logic [15:0]        req_angle,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_col0_x,
   output logic signed [31:0] rsp_col0_y,
   output logic signed [31:0] rsp_col1_x,
   output logic signed [31:0] rsp_col1_y,
   output logic signed [31:0] rsp_glob_x,
   output logic signed [31:0] rsp_glob_y
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_TRIG,
      S_MUL,
      S_WRITE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic       phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // captured request
   logic [1:0]         type_ff;
   logic [IDX_W-1:0]   node_ff, par_idx_ff;
   logic               par_ff;
   logic [15:0]        angle_ff;
   logic signed [15:0] sx_ff, sy_ff;
   logic signed [31:0] lx_ff, ly_ff;

   // local matrix, composed matrix and position
   logic signed [31:0] l00_ff, l01_ff, l10_ff, l11_ff;
   logic signed [31:0] m00_ff, m01_ff, m10_ff, m11_ff;
   logic signed [31:0] gx_ff, gy_ff;
   node_type           rsp_ff;

   logic               accept;
   logic               trig_done;
   logic signed [31:0] cos_v, sin_v;
   node_type           rd_par, rd_node, wd;
   logic               store_we, store_re;
   logic               mat_upd, pos_upd;

   mac_kind_type       kind;
   logic signed [31:0] op_a, op_b, addend, mac_res, sx32, sy32;
   logic               issue;

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign store_re  = (state_ff == S_READ);
   assign store_we  = (state_ff == S_WRITE);
   assign issue     = (state_ff == S_MUL) & ~phase_ff;
   assign sx32      = 32'(sx_ff);
   assign sy32      = 32'(sy_ff);

   tcu_store u_store (
      .clock   (clock),
      .we      (store_we),
      .waddr   (node_ff),
      .wdata   (wd),
      .re      (store_re),
      .raddr_a (par_idx_ff),
      .raddr_b (node_ff),
      .rdata_a (rd_par),
      .rdata_b (rd_node)
   );

   tcu_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (store_re),
      .angle   (angle_ff),
      .done    (trig_done),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   tcu_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .kind   (kind),
      .a      (op_a),
      .b      (op_b),
      .addend (addend),
      .res    (mac_res)
   );

   // product schedule: 4 local entries, 4 matrix pairs, 2 position pairs
   always_comb begin
      case (op_ff)
         4'd0:    begin op_a = sx32;      op_b = cos_v;  end
         4'd1:    begin op_a = sx32;      op_b = sin_v;  end
         4'd2:    begin op_a = -sy32;     op_b = sin_v;  end
         4'd3:    begin op_a = sy32;      op_b = cos_v;  end
         4'd4:    begin op_a = rd_par.c0x; op_b = l00_ff; end
         4'd5:    begin op_a = rd_par.c1x; op_b = l01_ff; end
         4'd6:    begin op_a = rd_par.c0y; op_b = l00_ff; end
         4'd7:    begin op_a = rd_par.c1y; op_b = l01_ff; end
         4'd8:    begin op_a = rd_par.c0x; op_b = l10_ff; end
         4'd9:    begin op_a = rd_par.c1x; op_b = l11_ff; end
         4'd10:   begin op_a = rd_par.c0y; op_b = l10_ff; end
         4'd11:   begin op_a = rd_par.c1y; op_b = l11_ff; end
         4'd12:   begin op_a = rd_par.c0x; op_b = lx_ff;  end
         4'd13:   begin op_a = rd_par.c1x; op_b = ly_ff;  end
         4'd14:   begin op_a = rd_par.c0y; op_b = lx_ff;  end
         default: begin op_a = rd_par.c1y; op_b = ly_ff;  end
      endcase
      if (op_ff < 4'd4)
         kind = MK_LOCAL;
      else if (!op_ff[0])
         kind = MK_FIRST;
      else if (op_ff == 4'd13 || op_ff == 4'd15)
         kind = MK_POS;
      else
         kind = MK_PAIR;
      addend = op_ff[1] ? rd_par.py : rd_par.px;
   end

   // merge of the updated parts into the stored node
   always_comb begin
      mat_upd = (type_ff == RT_BOTH) || (type_ff == RT_MAT);
      pos_upd = (type_ff == RT_BOTH) || (type_ff == RT_POS);
      wd = rd_node;
      if (mat_upd) begin
         wd.c0x = par_ff ? m00_ff : l00_ff;
         wd.c0y = par_ff ? m01_ff : l01_ff;
         wd.c1x = par_ff ? m10_ff : l10_ff;
         wd.c1y = par_ff ? m11_ff : l11_ff;
      end
      if (pos_upd) begin
         wd.px = par_ff ? gx_ff : lx_ff;
         wd.py = par_ff ? gy_ff : ly_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_TRIG;
         end
         S_TRIG: begin
            if (trig_done) begin
               state_in = S_MUL;
               op_in    = '0;
               phase_in = 1'b0;
            end
         end
         S_MUL: begin
            phase_in = ~phase_ff;
            if (phase_ff) begin
               op_in = op_ff + 1'b1;
               if (op_ff == 4'd15) state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in     = S_RESP;
            rsp_valid_in = 1'b1;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         type_ff    <= req_type;
         node_ff    <= IDX_W'(req_node_index);
         par_idx_ff <= IDX_W'(req_parent_index);
         par_ff     <= req_has_parent;
         angle_ff   <= req_angle;
         sx_ff      <= req_scale_x;
         sy_ff      <= req_scale_y;
         lx_ff      <= req_pos_x;
         ly_ff      <= req_pos_y;
      end
      // result capture in the later phase of each product
      if (state_ff == S_MUL && phase_ff) begin
         case (op_ff)
            4'd0:    l00_ff <= mac_res;
            4'd1:    l01_ff <= mac_res;
            4'd2:    l10_ff <= mac_res;
            4'd3:    l11_ff <= mac_res;
            4'd5:    m00_ff <= mac_res;
            4'd7:    m01_ff <= mac_res;
            4'd9:    m10_ff <= mac_res;
            4'd11:   m11_ff <= mac_res;
            4'd13:   gx_ff  <= mac_res;
            4'd15:   gy_ff  <= mac_res;
            default: ;
         endcase
      end
      if (store_we) begin
         rsp_ff <= wd;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_col0_x = rsp_ff.c0x;
   assign rsp_col0_y = rsp_ff.c0y;
   assign rsp_col1_x = rsp_ff.c1x;
   assign rsp_col1_y = rsp_ff.c1y;
   assign rsp_glob_x = rsp_ff.px;
   assign rsp_glob_y = rsp_ff.py;

   // no new transaction while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   // trig results only arrive while the sequencer waits for them
   a_trig_wait: assert property (@(posedge clock) disable iff (reset)
      trig_done |-> state_ff == S_TRIG)
      else $error("cordic finished outside trig wait");

   // each table write is followed by its response
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      store_we |=> rsp_valid)
      else $error("table write without response");

endmodule

// ===== tb/tb_hierarchical_2d_transform_compose_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hierarchical_2d_transform_compose_unit
// drives node update transactions through the compose unit and compares each
// response with a local scale-rotate-translate predictor over a shadow node
// table; directed table first, then random parent chains with random idling
// ----------------------------------------------------------------------------
module tb_hierarchical_2d_transform_compose_unit import tcu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // request type with no update
   localparam logic [1:0] RT_NONE = 2'd3;
   localparam int N_RANDOM = 1000;
   localparam int QUIET_TAIL = 100;

   typedef struct {
      logic [1:0]         kind;
      logic [5:0]         node;
      logic [5:0]         parent;
      logic               has_par;
      logic [15:0]        ang;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } xform_req_type;

   typedef struct {
      logic signed [31:0] c0x;
      logic signed [31:0] c0y;
      logic signed [31:0] c1x;
      logic signed [31:0] c1y;
      logic signed [31:0] gx;
      logic signed [31:0] gy;
   } xform_rsp_type;

   // directed row: typed-in answer only where it is obvious
   typedef struct {
      xform_req_type req;
      logic          typed;
      xform_rsp_type rsp;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_type;
   logic [5:0]         req_node_index;
   logic [5:0]         req_parent_index;
   logic               req_has_parent;
   logic [15:0]        req_angle;
   logic signed [15:0] req_scale_x;
   logic signed [15:0] req_scale_y;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_col0_x;
   logic signed [31:0] rsp_col0_y;
   logic signed [31:0] rsp_col1_x;
   logic signed [31:0] rsp_col1_y;
   logic signed [31:0] rsp_glob_x;
   logic signed [31:0] rsp_glob_y;

   hierarchical_2d_transform_compose_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_node_index   (req_node_index),
      .req_parent_index (req_parent_index),
      .req_has_parent   (req_has_parent),
      .req_angle        (req_angle),
      .req_scale_x      (req_scale_x),
      .req_scale_y      (req_scale_y),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_col0_x       (rsp_col0_x),
      .rsp_col0_y       (rsp_col0_y),
      .rsp_col1_x       (rsp_col1_x),
      .rsp_col1_y       (rsp_col1_y),
      .rsp_glob_x       (rsp_glob_x),
      .rsp_glob_y       (rsp_glob_y)
   );

   // shadow node table and which parts of each entry were ever written
   logic signed [31:0] shadow_c0x [NODES];
   logic signed [31:0] shadow_c0y [NODES];
   logic signed [31:0] shadow_c1x [NODES];
   logic signed [31:0] shadow_c1y [NODES];
   logic signed [31:0] shadow_px  [NODES];
   logic signed [31:0] shadow_py  [NODES];
   bit                 mat_known  [NODES];
   bit                 pos_known  [NODES];

   xform_rsp_type    pending_transforms[$];
   directed_row_type directed_rows[$];
   int  mismatches = 0;
   int  sent = 0;
   int  received = 0;
   bit  quiet = 0;
   bit  hold_off = 0;
   bit  stim_done = 0;

   // clock and the one reset at the start
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // hard limit on the run
   initial begin
      #5ms;
      $display("tb_hierarchical_2d_transform_compose_unit failed");
      $finish;
   end

   task automatic report_mismatch(input string field, input int idx,
                                  input logic signed [31:0] got,
                                  input logic signed [31:0] want);
      $display("mismatch rsp %0d %s: got %h expected %h", idx, field, got, want);
      mismatches++;
   endtask

   // round-half-up shift by 16 on a wide signed value
   function automatic logic signed [65:0] round_q16(input logic signed [65:0] v);
      return (v + 66'sd32768) >>> 16;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // round((a*b + c*d) / 2^16) kept exact in 66 bits
   function automatic logic signed [65:0] pair_dot(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic signed [31:0] c,
                                                   input logic signed [31:0] d);
      logic signed [65:0] s;
      s = 66'(a) * 66'(b) + 66'(c) * 66'(d);
      return round_q16(s);
   endfunction

   // 16-step cordic sine and cosine in Q1.30, quadrant applied exactly
   function automatic void cordic_sincos(input logic [15:0] ang, output longint co,
                                         output longint si);
      longint x, y, z, dx, dy, t;
      int     i;
      x = 652032874;
      y = 0;
      z = longint'(ang[13:0]) << 4;
      for (i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         t = longint'(atan_units(i[3:0]));
         if (z >= 0) begin
            x -= dx; y += dy; z -= t;
         end else begin
            x += dx; y -= dy; z += t;
         end
      end
      if (x > 1073741824) x = 1073741824;
      if (x < -1073741824) x = -1073741824;
      if (y > 1073741824) y = 1073741824;
      if (y < -1073741824) y = -1073741824;
      case (ang[15:14])
         2'd0: begin co = x;  si = y;  end
         2'd1: begin co = -y; si = x;  end
         2'd2: begin co = -x; si = -y; end
         default: begin co = y; si = -x; end
      endcase
   endfunction

   // Q8.8 scale times Q1.30 trig, rounded to Q16.16
   function automatic logic signed [65:0] local_term(input longint scale, input longint t);
      return 66'((scale * t + (longint'(1) << 21)) >>> 22);
   endfunction

   // apply one accepted transaction to the shadow table, return the node's state
   function automatic xform_rsp_type compose_node(input xform_req_type r);
      xform_rsp_type      o;
      longint             co, si;
      logic signed [31:0] p00, p01, p10, p11, ppx, ppy;
      logic signed [31:0] l00, l01, l10, l11;
      int                 n, p;
      n = r.node;
      p = r.parent;
      p00 = shadow_c0x[p]; p01 = shadow_c0y[p];
      p10 = shadow_c1x[p]; p11 = shadow_c1y[p];
      ppx = shadow_px[p];  ppy = shadow_py[p];
      if (r.kind == RT_BOTH || r.kind == RT_MAT) begin
         cordic_sincos(r.ang, co, si);
         l00 = clamp32(local_term(longint'(r.sx), co));
         l01 = clamp32(local_term(longint'(r.sx), si));
         l10 = clamp32(local_term(-longint'(r.sy), si));
         l11 = clamp32(local_term(longint'(r.sy), co));
         if (r.has_par) begin
            shadow_c0x[n] = clamp32(pair_dot(p00, l00, p10, l01));
            shadow_c0y[n] = clamp32(pair_dot(p01, l00, p11, l01));
            shadow_c1x[n] = clamp32(pair_dot(p00, l10, p10, l11));
            shadow_c1y[n] = clamp32(pair_dot(p01, l10, p11, l11));
         end else begin
            shadow_c0x[n] = l00; shadow_c0y[n] = l01;
            shadow_c1x[n] = l10; shadow_c1y[n] = l11;
         end
         mat_known[n] = 1;
      end
      if (r.kind == RT_BOTH || r.kind == RT_POS) begin
         if (r.has_par) begin
            shadow_px[n] = clamp32(66'(ppx) + pair_dot(p00, r.px, p10, r.py));
            shadow_py[n] = clamp32(66'(ppy) + pair_dot(p01, r.px, p11, r.py));
         end else begin
            shadow_px[n] = r.px;
            shadow_py[n] = r.py;
         end
         pos_known[n] = 1;
      end
      o.c0x = shadow_c0x[n]; o.c0y = shadow_c0y[n];
      o.c1x = shadow_c1x[n]; o.c1y = shadow_c1y[n];
      o.gx  = shadow_px[n];  o.gy  = shadow_py[n];
      return o;
   endfunction

   function automatic directed_row_type make_row(input logic [1:0] kind, input int node,
                                                 input int parent, input bit has_par,
                                                 input logic [15:0] ang,
                                                 input logic signed [15:0] sx,
                                                 input logic signed [15:0] sy,
                                                 input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input bit typed);
      directed_row_type d;
      d.req = '{kind, node[5:0], parent[5:0], has_par, ang, sx, sy, px, py};
      d.typed = typed;
      // zero scale gives a zero matrix, no parent passes the position through
      d.rsp = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, px, py};
      return d;
   endfunction

   // values biased toward a usable range, full range now and then
   function automatic logic signed [15:0] rand_scale();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(0, 1024)) - 512);
   endfunction

   function automatic logic signed [31:0] rand_pos();
      if ($urandom_range(0, 3) == 0) return 32'($urandom);
      return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
   endfunction

   // random transaction that never reads a node part that was never written
   function automatic xform_req_type random_req();
      xform_req_type r;
      int            n;
      r.node = 6'($urandom_range(0, 63));
      r.parent = 6'($urandom_range(0, 63));
      // favor a parent that is fully known, which makes deep chains
      for (int k = 0; k < 8 && !(mat_known[r.parent] && pos_known[r.parent]); k++)
         r.parent = 6'($urandom_range(0, 63));
      r.has_par = ($urandom_range(0, 9) < 7) && mat_known[r.parent] && pos_known[r.parent];
      r.kind = 2'($urandom_range(0, 9) < 6 ? RT_BOTH : $urandom_range(1, 3));
      n = r.node;
      if ((r.kind == RT_POS && !mat_known[n]) || (r.kind == RT_MAT && !pos_known[n]) ||
          (r.kind == RT_NONE && !(mat_known[n] && pos_known[n])))
         r.kind = RT_BOTH;
      r.ang = 16'($urandom);
      r.sx = rand_scale();
      r.sy = rand_scale();
      r.px = rand_pos();
      r.py = rand_pos();
      return r;
   endfunction

   // directed rows: extremes, every request type, self parent, unused type
   initial begin
      directed_rows.push_back(make_row(RT_BOTH, 0, 0, 0, 16'h0000, 16'sd0, 16'sd0,
                                       32'sh7fffffff, 32'sh80000000, 1));
      directed_rows.push_back(make_row(RT_BOTH, 1, 0, 0, 16'h0000, 16'sh7fff, 16'sh8000,
                                       32'sd0, 32'sd0, 0));
      directed_rows.push_back(make_row(RT_BOTH, 2, 1, 1, 16'h4000, 16'sh8000, 16'sh7fff,
                                       32'sh7fffffff, 32'sh7fffffff, 0));
      directed_rows.push_back(make_row(RT_BOTH, 3, 2, 1, 16'h8000, 16'sd256, 16'sd256,
                                       32'sh80000000, 32'sh7fffffff, 0));
      directed_rows.push_back(make_row(RT_BOTH, 4, 3, 1, 16'hc000, 16'sd384, -16'sd128,
                                       32'sh0001_0000, -32'sh0003_0000, 0));
      directed_rows.push_back(make_row(RT_BOTH, 5, 0, 0, 16'hffff, 16'sd256, 16'sd256,
                                       32'sh0010_0000, 32'sh0020_0000, 0));
      directed_rows.push_back(make_row(RT_BOTH, 6, 5, 1, 16'h2000, 16'sd512, 16'sd64,
                                       32'sh0000_8000, 32'shffff_8000, 0));
      directed_rows.push_back(make_row(RT_POS, 1, 2, 1, 16'h1234, 16'sd1, 16'sd1,
                                       32'sh80000000, 32'sh80000000, 0));
      directed_rows.push_back(make_row(RT_MAT, 2, 5, 1, 16'h3039, 16'sd300, -16'sd300,
                                       32'sd5, 32'sd7, 0));
      directed_rows.push_back(make_row(RT_NONE, 2, 3, 1, 16'hffff, 16'sh7fff, 16'sh7fff,
                                       32'sh7fffffff, 32'sh7fffffff, 0));
      // node reads itself as parent before being overwritten
      directed_rows.push_back(make_row(RT_BOTH, 3, 3, 1, 16'h6000, 16'sd200, 16'sd260,
                                       32'sh0002_0000, 32'sh0004_0000, 0));
      directed_rows.push_back(make_row(RT_BOTH, 63, 0, 0, 16'hffff, 16'sd0, 16'sd0,
                                       32'sd0, 32'sd0, 1));
      directed_rows.push_back(make_row(RT_BOTH, 7, 63, 1, 16'h0001, 16'sd256, 16'sd256,
                                       32'sh7fffffff, 32'sh80000000, 0));
      directed_rows.push_back(make_row(RT_POS, 63, 0, 0, 16'h0000, 16'sd0, 16'sd0,
                                       -32'sd1, 32'sd1, 1));
      directed_rows.push_back(make_row(RT_MAT, 0, 6, 1, 16'h7fff, 16'sh7fff, 16'sh8000,
                                       32'sd0, 32'sd0, 0));
      directed_rows.push_back(make_row(RT_BOTH, 8, 0, 1, 16'habcd, 16'sh7fff, 16'sh7fff,
                                       32'sh7fffffff, 32'sh7fffffff, 0));
   end

   // request side
   initial begin
      xform_req_type    r;
      xform_rsp_type    o;
      directed_row_type d;
      int               total;
      req_valid = 1'b0;
      req_type = '0; req_node_index = '0; req_parent_index = '0; req_has_parent = 1'b0;
      req_angle = '0; req_scale_x = '0; req_scale_y = '0; req_pos_x = '0; req_pos_y = '0;
      @(posedge clock);
      while (reset) @(posedge clock);
      total = directed_rows.size() + N_RANDOM;
      for (int i = 0; i < total; i++) begin
         if (i >= total - QUIET_TAIL) quiet = 1;
         if (i < directed_rows.size()) begin
            d = directed_rows[i];
            r = d.req;
         end else begin
            d.typed = 0;
            r = random_req();
         end
         // idle burst on the request side
         if (!quiet && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_valid        <= 1'b1;
         req_type         <= r.kind;
         req_node_index   <= r.node;
         req_parent_index <= r.parent;
         req_has_parent   <= r.has_par;
         req_angle        <= r.ang;
         req_scale_x      <= r.sx;
         req_scale_y      <= r.sy;
         req_pos_x        <= r.px;
         req_pos_y        <= r.py;
         do @(posedge clock); while (!req_ready);
         // transaction accepted at this edge
         o = compose_node(r);
         pending_transforms.push_back(d.typed ? d.rsp : o);
         sent++;
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // one long response stall while requests keep coming
   initial begin
      wait (sent >= 300);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
   end

   // response side: check, then choose next ready
   initial begin
      xform_rsp_type w;
      int            burst;
      burst = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_transforms.size() == 0) begin
               $display("response %0d arrived with nothing expected", received);
               mismatches++;
            end else begin
               w = pending_transforms.pop_front();
               if (rsp_col0_x !== w.c0x) report_mismatch("col0_x", received, rsp_col0_x, w.c0x);
               if (rsp_col0_y !== w.c0y) report_mismatch("col0_y", received, rsp_col0_y, w.c0y);
               if (rsp_col1_x !== w.c1x) report_mismatch("col1_x", received, rsp_col1_x, w.c1x);
               if (rsp_col1_y !== w.c1y) report_mismatch("col1_y", received, rsp_col1_y, w.c1y);
               if (rsp_glob_x !== w.gx)  report_mismatch("glob_x", received, rsp_glob_x, w.gx);
               if (rsp_glob_y !== w.gy)  report_mismatch("glob_y", received, rsp_glob_y, w.gy);
            end
            received++;
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // end of run: drain, then allow a full transaction time for strays
   initial begin
      wait (stim_done);
      while (pending_transforms.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (mismatches == 0)
         $display("tb_hierarchical_2d_transform_compose_unit passed");
      else
         $display("tb_hierarchical_2d_transform_compose_unit failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tcu_pkg.sv
rtl/tcu_store.sv
rtl/tcu_cordic.sv
rtl/tcu_mac.sv
rtl/hierarchical_2d_transform_compose_unit.sv
tb/tb_hierarchical_2d_transform_compose_unit.sv
